/* rtl/page_frame_allocator_refcount_assert.svh */
// Assertion macros of the page frame allocator, used by pfa_ctrl.
// Depends on nothing; included by the files that hold concurrent checks.
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfa assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfa assertion failed");

`endif

/* rtl/pfa_pkg.sv */
// Package of the page frame allocator: field widths, request and status codes,
// and the sequencer state type. Depends on nothing.
package pfa_pkg;

   localparam int NUM_PAGES_DEF = 32768;
   localparam int PAGE_W        = 15;
   localparam int INDEX_W       = 16;
   localparam int COUNT_W       = 8;
   localparam int REQ_W         = 3;
   localparam int STATUS_W      = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC = 3'd0,
      REQ_FREE  = 3'd1,
      REQ_INC   = 3'd2,
      REQ_DEC   = 3'd3,
      REQ_READ  = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

/* rtl/pfa_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the free-page stack and the reference count table; uses pfa_pkg.
module pfa_ram
   import pfa_pkg::*;
#(
   parameter int DEPTH = NUM_PAGES_DEF,
   parameter int WIDTH = PAGE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pfa_ctrl.sv */
// Request sequencer of the page frame allocator: clear pass, memory reads,
// read-modify-write of counts and stack, and the response register.
// Uses pfa_pkg and the assertion macro header.
`include "page_frame_allocator_refcount_assert.svh"

module pfa_ctrl
   import pfa_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [REQ_W-1:0]             req_type,
   input  logic [INDEX_W-1:0]           req_page_index,
   input  logic [PAGE_W-1:0]            first_usable_page,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [PAGE_W-1:0]            rsp_result_page,
   output logic [COUNT_W-1:0]           rsp_ref_count,
   // Reference count table.
   output logic                         refs_wr_en,
   output logic [$clog2(NUM_PAGES)-1:0] refs_wr_addr,
   output logic [COUNT_W-1:0]           refs_wr_data,
   output logic                         refs_rd_en,
   output logic [$clog2(NUM_PAGES)-1:0] refs_rd_addr,
   input  logic [COUNT_W-1:0]           refs_rd_data,
   // Free-page stack.
   output logic                         stack_wr_en,
   output logic [$clog2(NUM_PAGES)-1:0] stack_wr_addr,
   output logic [PAGE_W-1:0]            stack_wr_data,
   output logic                         stack_rd_en,
   output logic [$clog2(NUM_PAGES)-1:0] stack_rd_addr,
   input  logic [PAGE_W-1:0]            stack_rd_data
);

   localparam int PW = $clog2(NUM_PAGES);
   localparam int CW = $clog2(NUM_PAGES + 1);
   localparam logic [PW-1:0] LAST_ADDR = PW'(NUM_PAGES - 1);
   localparam logic [CW-1:0] FULL_FILL = CW'(NUM_PAGES);

   state_type           state_ff, state_in;
   logic [PW-1:0]       clr_addr_ff, clr_addr_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [REQ_W-1:0]    type_ff;
   logic [INDEX_W-1:0]  page_ff;
   logic                bad_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [PAGE_W-1:0]   result_page_ff;
   logic [COUNT_W-1:0]  ref_count_ff;

   logic                accept;
   logic                commit;
   logic                out_free;
   logic                bad_req;
   logic [CW-1:0]       pop_idx;
   logic [INDEX_W-1:0]  got_ext;
   logic                alloc_ok;
   status_type          st_c;
   logic [PAGE_W-1:0]   pg_c;
   logic [COUNT_W-1:0]  cnt_c;
   logic                cw_en_c;
   logic                cw_alloc_c;
   logic [COUNT_W-1:0]  cw_data_c;
   logic                push_c;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == ST_EXEC) && out_free;
   assign pop_idx  = fill_ff - CW'(1);
   assign got_ext  = {1'b0, stack_rd_data};

   // Unknown codes and pages outside the managed window are rejected up front.
   always_comb begin
      bad_req = 1'b0;
      if (req_type > REQ_READ) begin
         bad_req = 1'b1;
      end else if (req_type != REQ_ALLOC) begin
         if (req_page_index < {1'b0, first_usable_page}) begin
            bad_req = 1'b1;
         end
         if ({1'b0, req_page_index} >= (INDEX_W + 1)'(NUM_PAGES)) begin
            bad_req = 1'b1;
         end
      end
   end

   // Sequencer state, clear counter and stack fill.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Transaction capture at accept and response payload at commit.
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         page_ff <= req_page_index;
         bad_ff  <= bad_req;
      end
      if (commit) begin
         status_ff      <= st_c;
         result_page_ff <= pg_c;
         ref_count_ff   <= cnt_c;
      end
   end

   // Result of the request, from the data read in the accept cycle.
   always_comb begin
      st_c       = STATUS_OK;
      pg_c       = '0;
      cnt_c      = '0;
      cw_en_c    = 1'b0;
      cw_alloc_c = 1'b0;
      cw_data_c  = '0;
      push_c     = 1'b0;
      if (bad_ff) begin
         st_c = STATUS_INVALID;
      end else begin
         case (type_ff)
            REQ_ALLOC: begin
               if (fill_ff == '0) begin
                  st_c = STATUS_EMPTY;
               end else begin
                  pg_c       = stack_rd_data;
                  cnt_c      = COUNT_ONE;
                  cw_en_c    = 1'b1;
                  cw_alloc_c = 1'b1;
                  cw_data_c  = COUNT_ONE;
               end
            end
            REQ_FREE: begin
               if (refs_rd_data > COUNT_ONE) begin
                  cnt_c     = refs_rd_data - COUNT_ONE;
                  cw_en_c   = 1'b1;
                  cw_data_c = refs_rd_data - COUNT_ONE;
               end else if (fill_ff == FULL_FILL) begin
                  st_c  = STATUS_FULL;
                  cnt_c = refs_rd_data;
               end else begin
                  cnt_c  = refs_rd_data;
                  push_c = 1'b1;
               end
            end
            REQ_INC: begin
               cnt_c     = (refs_rd_data == COUNT_MAX) ? refs_rd_data
                                                       : refs_rd_data + COUNT_ONE;
               cw_en_c   = 1'b1;
               cw_data_c = cnt_c;
            end
            REQ_DEC: begin
               cnt_c     = (refs_rd_data == '0) ? refs_rd_data
                                                : refs_rd_data - COUNT_ONE;
               cw_en_c   = 1'b1;
               cw_data_c = cnt_c;
            end
            REQ_READ: begin
               cnt_c = refs_rd_data;
            end
            default: begin
               st_c = STATUS_INVALID;
            end
         endcase
      end
   end

   assign alloc_ok = commit && cw_alloc_c;

   // Next state, memory strobes and response valid.
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff;
      req_ready     = 1'b0;
      refs_wr_en    = 1'b0;
      refs_wr_addr  = page_ff[PW-1:0];
      refs_wr_data  = cw_data_c;
      stack_wr_en   = 1'b0;
      stack_wr_addr = fill_ff[PW-1:0];
      stack_wr_data = page_ff[PAGE_W-1:0];
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            refs_wr_en   = 1'b1;
            refs_wr_addr = clr_addr_ff;
            refs_wr_data = '0;
            clr_addr_in  = clr_addr_ff + PW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               refs_wr_en   = cw_en_c;
               if (cw_alloc_c) begin
                  refs_wr_addr = got_ext[PW-1:0];
                  fill_in      = pop_idx;
               end
               if (push_c) begin
                  stack_wr_en = 1'b1;
                  fill_in     = fill_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Reads go out in the accept cycle; the data is ready in the execute cycle.
   assign refs_rd_en    = accept;
   assign refs_rd_addr  = req_page_index[PW-1:0];
   assign stack_rd_en   = accept;
   assign stack_rd_addr = pop_idx[PW-1:0];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_page = result_page_ff;
   assign rsp_ref_count   = ref_count_ff;

   // Checks on the sequencer.
   `PFA_ASSERT_IMP(a_clear_blocks_req, clock, reset, state_ff == ST_CLEAR, !req_ready)
   `PFA_ASSERT_NEXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC)
   `PFA_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= FULL_FILL)
   `PFA_ASSERT_NEXT(a_alloc_pops, clock, reset, alloc_ok,
                    fill_ff == $past(fill_ff) - CW'(1))
   `PFA_ASSERT_IMP(a_no_double_write, clock, reset, refs_wr_en && stack_wr_en,
                   state_ff == ST_EXEC && type_ff == REQ_FREE && 1'b0)

endmodule

/* rtl/page_frame_allocator_refcount.sv */
// Page frame allocator with per-page reference counts.
// Request channel (req_): valid/ready with req_type and req_page_index.
// Response channel (rsp_): valid/ready with status, granted page and count.
// Configuration: csr_write_enable writes csr_write_data into first_usable_page.
// After reset the count table is cleared, one entry a cycle, over all NUM_PAGES
// entries; req_ready stays low during that pass, and the free stack is empty.
// For each request the count table and the stack top are read in the accept
// cycle; in the execute state, once the response register is free, the entry
// is written back and the response register is loaded, raising rsp_valid.
// req_ready is high only in the idle state, so a new request is accepted
// only after the previous one has been written back to the memories.
// The response register lets a new request be accepted while a response waits;
// if the receiver stalls, that request holds in its write-back cycle until the
// response register frees, and req_ready stays low meanwhile.
// Software must free every managed page once after the clear pass; the block
// does not enforce it. Depends on pfa_pkg, pfa_ram and pfa_ctrl.
module page_frame_allocator_refcount
   import pfa_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [INDEX_W-1:0]  req_page_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_result_page,
   output logic [COUNT_W-1:0]  rsp_ref_count,
   input  logic                csr_write_enable,
   input  logic [PAGE_W-1:0]   csr_write_data
);

   localparam int PW = $clog2(NUM_PAGES);

   logic [PAGE_W-1:0]  first_page_ff;
   logic               refs_wr_en, refs_rd_en, stack_wr_en, stack_rd_en;
   logic [PW-1:0]      refs_wr_addr, refs_rd_addr, stack_wr_addr, stack_rd_addr;
   logic [COUNT_W-1:0] refs_wr_data, refs_rd_data;
   logic [PAGE_W-1:0]  stack_wr_data, stack_rd_data;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else if (csr_write_enable) begin
         first_page_ff <= csr_write_data;
      end
   end

   pfa_ctrl #(
      .NUM_PAGES (NUM_PAGES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_page_index    (req_page_index),
      .first_usable_page (first_page_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_page   (rsp_result_page),
      .rsp_ref_count     (rsp_ref_count),
      .refs_wr_en        (refs_wr_en),
      .refs_wr_addr      (refs_wr_addr),
      .refs_wr_data      (refs_wr_data),
      .refs_rd_en        (refs_rd_en),
      .refs_rd_addr      (refs_rd_addr),
      .refs_rd_data      (refs_rd_data),
      .stack_wr_en       (stack_wr_en),
      .stack_wr_addr     (stack_wr_addr),
      .stack_wr_data     (stack_wr_data),
      .stack_rd_en       (stack_rd_en),
      .stack_rd_addr     (stack_rd_addr),
      .stack_rd_data     (stack_rd_data)
   );

   // Reference count table.
   pfa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (COUNT_W)
   ) u_refs (
      .clock   (clock),
      .wr_en   (refs_wr_en),
      .wr_addr (refs_wr_addr),
      .wr_data (refs_wr_data),
      .rd_en   (refs_rd_en),
      .rd_addr (refs_rd_addr),
      .rd_data (refs_rd_data)
   );

   // Free-page stack.
   pfa_ram #(
      .DEPTH (NUM_PAGES),
      .WIDTH (PAGE_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (stack_rd_en),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

endmodule
